// ===== hdl/cov_pkg.sv =====
// Shared types, codes and helpers of the cursor overlay compositor.
package cov_pkg;

   localparam int CURSOR_DIM_DEFAULT = 128;
   localparam int MAX_SIDE_DEFAULT   = 16384;

   localparam int COORD_W     = 14;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 15;

   // item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_MAP   = 2'd1;
   localparam logic [1:0] KIND_BLEND = 2'd2;

   // rotation modes
   localparam logic [1:0] ROT_NONE = 2'd0;
   localparam logic [1:0] ROT_90   = 2'd1;
   localparam logic [1:0] ROT_180  = 2'd2;
   localparam logic [1:0] ROT_270  = 2'd3;

   // cursor types
   localparam logic [1:0] CTYPE_HIDDEN = 2'd0;
   localparam logic [1:0] CTYPE_MONO   = 2'd1;
   localparam logic [1:0] CTYPE_COLOR  = 2'd2;
   localparam logic [1:0] CTYPE_MASKED = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION_MODE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_TYPE   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_LEFT   = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_TOP    = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_SPAN_X = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_SPAN_Y = 4'd7;

   // register reset values
   localparam logic [1:0]  RST_ROTATION_MODE = ROT_NONE;
   localparam logic [14:0] RST_SOURCE_WIDTH  = 15'd1920;
   localparam logic [14:0] RST_SOURCE_HEIGHT = 15'd1080;
   localparam logic [1:0]  RST_CURSOR_TYPE   = CTYPE_HIDDEN;
   localparam logic [14:0] RST_CURSOR_LEFT   = 15'd0;
   localparam logic [14:0] RST_CURSOR_TOP    = 15'd0;
   localparam logic [7:0]  RST_CURSOR_SPAN   = 8'd0;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [7:0]         desk_blue;
      logic [7:0]         desk_green;
      logic [7:0]         desk_red;
      logic [COORD_W-1:0] cursor_index;
      logic [31:0]        cursor_word;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] source_x;
      logic [COORD_W-1:0] source_y;
      logic [7:0]         pix_blue;
      logic [7:0]         pix_green;
      logic [7:0]         pix_red;
   } rsp_type;

   // stage 1: coordinates resolved
   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic signed [16:0] loc_x;
      logic signed [16:0] loc_y;
      logic [7:0]         d_b;
      logic [7:0]         d_g;
      logic [7:0]         d_r;
      logic [COORD_W-1:0] idx;
      logic [31:0]        word;
      logic               load_ok;
   } stage_a_type;

   // stage 2: cursor hit decided, store read in flight
   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [7:0]         d_b;
      logic [7:0]         d_g;
      logic [7:0]         d_r;
      logic               hit;
      logic               in_dim;
   } stage_b_type;

   // stage 3: blend products summed
   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic               use_div;
      logic [15:0]        num_b;
      logic [15:0]        num_g;
      logic [15:0]        num_r;
      logic [7:0]         alt_b;
      logic [7:0]         alt_g;
      logic [7:0]         alt_r;
   } stage_c_type;

   // floor(n / 255), exact for every n below 65280
   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] t;
      t = 17'(n) + 17'(n >> 8) + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== hdl/cov_store.sv =====
// Cursor store: one write port and one registered read port.
module cov_store #(
   parameter int DEPTH = cov_pkg::CURSOR_DIM_DEFAULT * cov_pkg::CURSOR_DIM_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cursor_overlay_compositor.sv =====
// Cursor overlay compositor: four-stage pipeline that loads cursor words, maps rotated
// output coordinates back to the desktop and draws the cursor over desktop pixels.
//
// One item is taken every clock while the result side keeps up; each item's result is
// presented from the stage 4 register and can transfer at the following edge, with
// stalls held per stage so bubbles collapse.
// Stage 1 resolves the rotated source coordinate and the cursor-local coordinate, stage 2
// tests the cursor rectangle and reads the CURSOR_DIM x CURSOR_DIM word store (loads write
// it at the same point, so a blend right behind a load sees the new word), stage 3 forms
// the alpha products, and stage 4 divides colour sums by 255 with rounding and holds the
// result. The store is not cleared by reset: a never-loaded entry blends to unspecified
// colour. The user writes configuration only while no item is in flight; it is unchecked.
module cursor_overlay_compositor #(
   parameter int CURSOR_DIM = cov_pkg::CURSOR_DIM_DEFAULT,
   parameter int MAX_SIDE   = cov_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cov_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cov_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cov_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cov_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int STORE_DEPTH = CURSOR_DIM * CURSOR_DIM;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int IW          = $clog2(CURSOR_DIM);
   localparam int CW          = cov_pkg::COORD_W;
   localparam logic [14:0] MAX_SIDE_V = 15'(MAX_SIDE);

   // configuration registers
   logic [1:0]         rot_ff;
   logic [14:0]        width_ff;
   logic [14:0]        height_ff;
   logic [1:0]         ctype_ff;
   logic signed [14:0] left_ff;
   logic signed [14:0] top_ff;
   logic [7:0]         span_x_ff;
   logic [7:0]         span_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff    <= cov_pkg::RST_ROTATION_MODE;
         width_ff  <= cov_pkg::RST_SOURCE_WIDTH;
         height_ff <= cov_pkg::RST_SOURCE_HEIGHT;
         ctype_ff  <= cov_pkg::RST_CURSOR_TYPE;
         left_ff   <= cov_pkg::RST_CURSOR_LEFT;
         top_ff    <= cov_pkg::RST_CURSOR_TOP;
         span_x_ff <= cov_pkg::RST_CURSOR_SPAN;
         span_y_ff <= cov_pkg::RST_CURSOR_SPAN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cov_pkg::CSR_ROTATION_MODE: rot_ff    <= csr_data[1:0];
            cov_pkg::CSR_SOURCE_WIDTH:  width_ff  <= csr_data;
            cov_pkg::CSR_SOURCE_HEIGHT: height_ff <= csr_data;
            cov_pkg::CSR_CURSOR_TYPE:   ctype_ff  <= csr_data[1:0];
            cov_pkg::CSR_CURSOR_LEFT:   left_ff   <= csr_data;
            cov_pkg::CSR_CURSOR_TOP:    top_ff    <= csr_data;
            cov_pkg::CSR_CURSOR_SPAN_X: span_x_ff <= csr_data[7:0];
            cov_pkg::CSR_CURSOR_SPAN_Y: span_y_ff <= csr_data[7:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // pipeline flow control
   logic v_a_ff, v_b_ff, v_c_ff, v_d_ff;
   logic ready_a, ready_b, ready_c, ready_d;
   logic adv_a, adv_b, adv_c, adv_d;

   assign ready_d   = !v_d_ff || rsp_ready;
   assign ready_c   = !v_c_ff || ready_d;
   assign ready_b   = !v_b_ff || ready_c;
   assign ready_a   = !v_a_ff || ready_b;
   assign req_ready = ready_a;
   assign adv_a     = req_valid && ready_a;
   assign adv_b     = v_a_ff && ready_b;
   assign adv_c     = v_b_ff && ready_c;
   assign adv_d     = v_c_ff && ready_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
      end else begin
         if (ready_a) v_a_ff <= req_valid;
         if (ready_b) v_b_ff <= v_a_ff;
         if (ready_c) v_c_ff <= v_b_ff;
         if (ready_d) v_d_ff <= v_c_ff;
      end
   end

   // stage 1: rotation map and cursor-local coordinate
   cov_pkg::stage_a_type a_in, a_ff;
   logic [14:0]   w_sat, h_sat;
   logic [CW-1:0] w_m1, h_m1;

   always_comb begin
      w_sat = width_ff;
      if (width_ff == 15'd0) w_sat = 15'd1;
      else if (width_ff > MAX_SIDE_V) w_sat = MAX_SIDE_V;
      h_sat = height_ff;
      if (height_ff == 15'd0) h_sat = 15'd1;
      else if (height_ff > MAX_SIDE_V) h_sat = MAX_SIDE_V;
      // everything past here wraps modulo 2^14
      w_m1 = w_sat[CW-1:0] - CW'(1);
      h_m1 = h_sat[CW-1:0] - CW'(1);
   end

   always_comb begin
      a_in.kind = req_payload.kind;
      case (rot_ff)
         cov_pkg::ROT_90: begin
            a_in.src_x = req_payload.out_y;
            a_in.src_y = h_m1 - req_payload.out_x;
         end
         cov_pkg::ROT_180: begin
            a_in.src_x = w_m1 - req_payload.out_x;
            a_in.src_y = h_m1 - req_payload.out_y;
         end
         cov_pkg::ROT_270: begin
            a_in.src_x = w_m1 - req_payload.out_y;
            a_in.src_y = req_payload.out_x;
         end
         default: begin
            a_in.src_x = req_payload.out_x;
            a_in.src_y = req_payload.out_y;
         end
      endcase
      a_in.loc_x   = $signed({3'b000, req_payload.out_x}) - 17'(left_ff);
      a_in.loc_y   = $signed({3'b000, req_payload.out_y}) - 17'(top_ff);
      a_in.d_b     = req_payload.desk_blue;
      a_in.d_g     = req_payload.desk_green;
      a_in.d_r     = req_payload.desk_red;
      a_in.idx     = req_payload.cursor_index;
      a_in.word    = req_payload.cursor_word;
      a_in.load_ok = 32'(req_payload.cursor_index) < 32'(STORE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (adv_a) a_ff <= a_in;
   end

   // stage 2: rectangle test and store access
   cov_pkg::stage_b_type b_in, b_ff;
   logic          in_span;
   logic          st_wr_en;
   logic [AW-1:0] st_wr_addr, st_rd_addr;
   logic [31:0]   st_rd_data;

   always_comb begin
      in_span = !a_ff.loc_x[16] && !a_ff.loc_y[16] &&
                (a_ff.loc_x[15:0] < 16'(span_x_ff)) &&
                (a_ff.loc_y[15:0] < 16'(span_y_ff));
      b_in.kind   = a_ff.kind;
      b_in.src_x  = a_ff.src_x;
      b_in.src_y  = a_ff.src_y;
      b_in.d_b    = a_ff.d_b;
      b_in.d_g    = a_ff.d_g;
      b_in.d_r    = a_ff.d_r;
      b_in.hit    = in_span && (ctype_ff != cov_pkg::CTYPE_HIDDEN);
      b_in.in_dim = (a_ff.loc_x[15:0] < 16'(CURSOR_DIM)) &&
                    (a_ff.loc_y[15:0] < 16'(CURSOR_DIM));
   end

   assign st_wr_en   = adv_b && (a_ff.kind == cov_pkg::KIND_LOAD) && a_ff.load_ok;
   assign st_wr_addr = AW'(a_ff.idx);
   assign st_rd_addr = AW'(AW'(a_ff.loc_y[IW-1:0]) * AW'(CURSOR_DIM))
                     + AW'(a_ff.loc_x[IW-1:0]);

   cov_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (a_ff.word),
      .rd_en   (adv_b),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   always_ff @(posedge clock) begin
      if (adv_b) b_ff <= b_in;
   end

   // stage 3: per-channel blend terms
   cov_pkg::stage_c_type c_in, c_ff;
   logic [31:0] cw;
   logic [7:0]  c0, c1, c2, alpha, alpha_inv;

   always_comb begin
      // a word beyond the store dimension reads as zero
      cw        = b_ff.in_dim ? st_rd_data : 32'd0;
      c0        = cw[7:0];
      c1        = cw[15:8];
      c2        = cw[23:16];
      alpha     = cw[31:24];
      alpha_inv = 8'd255 - alpha;

      c_in.kind    = b_ff.kind;
      c_in.src_x   = b_ff.src_x;
      c_in.src_y   = b_ff.src_y;
      c_in.use_div = b_ff.hit && (ctype_ff == cov_pkg::CTYPE_COLOR);
      c_in.num_b   = 16'(16'(b_ff.d_b) * 16'(alpha_inv)) + 16'(16'(c0) * 16'(alpha))
                   + 16'd127;
      c_in.num_g   = 16'(16'(b_ff.d_g) * 16'(alpha_inv)) + 16'(16'(c1) * 16'(alpha))
                   + 16'd127;
      c_in.num_r   = 16'(16'(b_ff.d_r) * 16'(alpha_inv)) + 16'(16'(c2) * 16'(alpha))
                   + 16'd127;

      c_in.alt_b = b_ff.d_b;
      c_in.alt_g = b_ff.d_g;
      c_in.alt_r = b_ff.d_r;
      if (b_ff.hit) begin
         case (ctype_ff)
            cov_pkg::CTYPE_MONO: begin
               c_in.alt_b = (b_ff.d_b & c0) ^ c1;
               c_in.alt_g = (b_ff.d_g & c0) ^ c1;
               c_in.alt_r = (b_ff.d_r & c0) ^ c1;
            end
            cov_pkg::CTYPE_MASKED: begin
               c_in.alt_b = (alpha != 8'd0) ? (b_ff.d_b ^ c0) : c0;
               c_in.alt_g = (alpha != 8'd0) ? (b_ff.d_g ^ c1) : c1;
               c_in.alt_r = (alpha != 8'd0) ? (b_ff.d_r ^ c2) : c2;
            end
            default: begin
               // colour goes through the divider, hidden never hits
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c) c_ff <= c_in;
   end

   // stage 4: divide and form the result
   cov_pkg::rsp_type d_in, d_ff;
   logic [1:0]       d_kind_in, d_kind_ff;

   always_comb begin
      d_kind_in = c_ff.kind;
      d_in      = '0;
      if (c_ff.kind == cov_pkg::KIND_MAP) begin
         d_in.source_x = c_ff.src_x;
         d_in.source_y = c_ff.src_y;
      end
      if (c_ff.kind == cov_pkg::KIND_BLEND) begin
         d_in.pix_blue  = c_ff.use_div ? cov_pkg::div255(c_ff.num_b) : c_ff.alt_b;
         d_in.pix_green = c_ff.use_div ? cov_pkg::div255(c_ff.num_g) : c_ff.alt_g;
         d_in.pix_red   = c_ff.use_div ? cov_pkg::div255(c_ff.num_r) : c_ff.alt_r;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_d) begin
         d_ff      <= d_in;
         d_kind_ff <= d_kind_in;
      end
   end

   assign rsp_valid   = v_d_ff;
   assign rsp_payload = d_ff;

   // back-pressure reaches the input only when every stage is occupied
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v_a_ff && v_b_ff && v_c_ff && v_d_ff))
      else $error("input stalled with a free pipeline stage");

   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_a_ff)
      else $error("transfer did not reach stage 1");

   a_coord_only_for_map: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (d_kind_ff != cov_pkg::KIND_MAP)) |->
      (rsp_payload.source_x == '0 && rsp_payload.source_y == '0))
      else $error("source coordinate set on a non-map result");

   a_pixel_only_for_blend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (d_kind_ff != cov_pkg::KIND_BLEND)) |->
      (rsp_payload.pix_blue == '0 && rsp_payload.pix_green == '0 &&
       rsp_payload.pix_red == '0))
      else $error("pixel set on a non-blend result");

endmodule
